// ===== src/tlbpt_pkg.sv =====
// Package for the TLB and page table translator.
// Holds the fixed field widths, parameter defaults and outcome codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlbpt_pkg;

  // Field widths fixed by the item format
  localparam int VA_W   = 20;
  localparam int TIME_W = 32;
  localparam int PA_W   = 18;
  localparam int KIND_W = 2;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  // Parameter defaults
  localparam int DEF_TLB_ENTRIES = 8;
  localparam int DEF_FRAME_COUNT = 256;
  localparam int DEF_PAGE_COUNT  = 1024;
  localparam int DEF_PAGE_BYTES  = 1024;

  // Outcome codes
  localparam logic [KIND_W-1:0] OUT_TLB_HIT   = 2'd0;
  localparam logic [KIND_W-1:0] OUT_TABLE_HIT = 2'd1;
  localparam logic [KIND_W-1:0] OUT_FAULT     = 2'd2;
  localparam logic [KIND_W-1:0] OUT_NO_FRAME  = 2'd3;

endpackage

`default_nettype wire

// ===== src/tlbpt_table.sv =====
// Page table store: one synchronous memory of {valid, frame} words.
// Clears itself entry by entry after reset; depends on tlbpt_pkg for the PAGE_COUNT default.
`timescale 1ns / 1ps
`default_nettype none

module tlbpt_table #(
  parameter int PAGE_COUNT = tlbpt_pkg::DEF_PAGE_COUNT,
  parameter int FRAME_W    = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [((PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1)-1:0] rd_addr,
  output logic                                 rd_valid,
  output logic [FRAME_W-1:0]                   rd_frame,
  input  wire logic                            wr_en,
  input  wire logic [((PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1)-1:0] wr_addr,
  input  wire logic [FRAME_W-1:0]              wr_frame,
  output logic                                 ready
);
  import tlbpt_pkg::*;

  localparam int IDX_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  logic [FRAME_W:0]   mem [PAGE_COUNT];
  logic [FRAME_W:0]   rd_word;
  logic               clearing;
  logic [IDX_W-1:0]   clr_addr;

  assign ready    = !clearing;
  assign rd_valid = rd_word[FRAME_W];
  assign rd_frame = rd_word[FRAME_W-1:0];

  // Sweep every entry to invalid after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == IDX_W'(PAGE_COUNT - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b1, wr_frame};
    end
  end

  always_ff @(posedge clk) begin
    rd_word <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== src/tlb_page_table_translator.sv =====
// Flow: an accepted item passes SPLIT, LOOK, TABLE, then FILL when a TLB refill
// is needed, and its result is loaded in OUT; the refill waits for the victim
// scan, which checks one TLB entry per cycle. A stalled output holds it in OUT.
// A new item is taken only back in IDLE, once the last result is loaded.
// Reset: synchronous, clears the TLB at once; the page table is then swept
// one entry per cycle over all PAGE_COUNT entries, while no item is taken.
`timescale 1ns / 1ps
`default_nettype none

module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
  parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT,
  parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT,
  parameter int PAGE_BYTES  = tlbpt_pkg::DEF_PAGE_BYTES
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // virtual_address [19:0], request_time [51:20], zeros above
  input  wire logic [tlbpt_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // physical_address [17:0], zeros above
  output logic [tlbpt_pkg::OUT_DATA_W-1:0]        m_tdata,
  // outcome [1:0]
  output logic [tlbpt_pkg::KIND_W-1:0]            m_tuser
);
  import tlbpt_pkg::*;

  localparam int FRAME_W  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int FREE_W   = $clog2(FRAME_COUNT + 1);
  localparam int TIDX_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int VIDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int OFF_W    = $clog2(PAGE_BYTES);
  localparam int PAGE_MAX = ((2 ** VA_W) - 1) / PAGE_BYTES;
  localparam int PAGE_W   = (PAGE_MAX > 0) ? $clog2(PAGE_MAX + 1) : 1;
  // Page number by reciprocal multiply: exact for every VA_W-bit address
  localparam int DIV_S    = VA_W + OFF_W;
  localparam int RCP_W    = VA_W + 1;
  localparam longint DIV_M = ((64'd1 << DIV_S) + PAGE_BYTES - 1) / PAGE_BYTES;
  localparam int PROD_W   = VA_W + RCP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPLIT = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_TABLE = 3'd3;
  localparam logic [2:0] ST_FILL  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0]          state;
  logic [VA_W-1:0]     va;
  logic [TIME_W-1:0]   stamp;
  logic [PAGE_W-1:0]   page;
  logic [OFF_W-1:0]    offset;
  logic                in_range;
  logic                tlb_hit;
  logic [FRAME_W-1:0]  hit_frame;
  logic [FRAME_W-1:0]  frame;
  logic [KIND_W-1:0]   outcome;
  logic [FREE_W-1:0]   free_count;

  logic [PAGE_W-1:0]   tlb_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0]  tlb_frame [TLB_ENTRIES];
  logic [TIME_W-1:0]   tlb_birth [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;

  logic [VIDX_W-1:0]   scan_idx;
  logic                scan_done;
  logic [VIDX_W-1:0]   victim;
  logic [TIME_W-1:0]   best_birth;

  logic [PA_W-1:0]     pa_out;

  logic                accept;
  logic                out_load;
  logic                table_ready;
  logic                rd_valid;
  logic [FRAME_W-1:0]  rd_frame;
  logic                wr_en;
  logic                frame_free;
  logic                hit_any;
  logic [FRAME_W-1:0]  hit_f;
  logic [PROD_W-1:0]   quot_prod;
  logic [VA_W-1:0]     page_base;
  logic [PA_W-1:0]     pa_next;

  assign s_tready   = (state == ST_IDLE) && table_ready;
  assign accept     = s_tvalid && s_tready;
  assign out_load   = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign frame_free = free_count < FREE_W'(FRAME_COUNT);
  assign wr_en      = (state == ST_TABLE) && !tlb_hit && in_range && !rd_valid
                      && frame_free;

  assign quot_prod = PROD_W'(va) * PROD_W'(DIV_M);
  assign page_base = VA_W'(VA_W'(page) * VA_W'(PAGE_BYTES));
  assign pa_next   = (outcome == OUT_NO_FRAME) ? '0 :
                     PA_W'(PA_W'(frame) * PA_W'(PAGE_BYTES)) + PA_W'(offset);

  // First valid matching entry wins
  always_comb begin
    hit_any = 1'b0;
    hit_f   = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (tlb_page[i] == page)) begin
        hit_any = 1'b1;
        hit_f   = tlb_frame[i];
      end
    end
  end

  tlbpt_table #(
    .PAGE_COUNT (PAGE_COUNT),
    .FRAME_W    (FRAME_W)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (TIDX_W'(page)),
    .rd_valid (rd_valid),
    .rd_frame (rd_frame),
    .wr_en    (wr_en),
    .wr_addr  (TIDX_W'(page)),
    .wr_frame (FRAME_W'(free_count)),
    .ready    (table_ready)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_count <= '0;
      tlb_valid  <= '0;
      m_tvalid   <= 1'b0;
      scan_done  <= 1'b1;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        free_count <= free_count + 1'b1;
      end
      // Victim scan: first invalid entry, else oldest birth, lowest index on ties
      if (accept) begin
        scan_done <= 1'b0;
      end else if (!scan_done) begin
        if (!tlb_valid[scan_idx] || (scan_idx == VIDX_W'(TLB_ENTRIES - 1))) begin
          scan_done <= 1'b1;
        end
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_SPLIT;
          end
        end
        ST_SPLIT: state <= ST_LOOK;
        ST_LOOK:  state <= ST_TABLE;
        ST_TABLE: begin
          if (!tlb_hit && in_range && (rd_valid || frame_free)) begin
            state <= ST_FILL;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_FILL: begin
          if (scan_done) begin
            tlb_valid[victim] <= 1'b1;
            state             <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      va         <= s_tdata[VA_W-1:0];
      stamp      <= s_tdata[VA_W +: TIME_W];
      scan_idx   <= '0;
      victim     <= '0;
      best_birth <= '1;
    end else if (!scan_done) begin
      if (!tlb_valid[scan_idx]) begin
        victim <= scan_idx;
      end else begin
        if (tlb_birth[scan_idx] < best_birth) begin
          victim     <= scan_idx;
          best_birth <= tlb_birth[scan_idx];
        end
        if (scan_idx != VIDX_W'(TLB_ENTRIES - 1)) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
    end
    if (state == ST_SPLIT) begin
      page <= quot_prod[DIV_S +: PAGE_W];
    end
    if (state == ST_LOOK) begin
      offset    <= OFF_W'(va - page_base);
      in_range  <= 32'(page) < PAGE_COUNT;
      tlb_hit   <= hit_any;
      hit_frame <= hit_f;
    end
    if (state == ST_TABLE) begin
      priority if (tlb_hit) begin
        frame   <= hit_frame;
        outcome <= OUT_TLB_HIT;
      end else if (!in_range) begin
        frame   <= '0;
        outcome <= OUT_NO_FRAME;
      end else if (rd_valid) begin
        frame   <= rd_frame;
        outcome <= OUT_TABLE_HIT;
      end else if (frame_free) begin
        frame   <= FRAME_W'(free_count);
        outcome <= OUT_FAULT;
      end else begin
        frame   <= '0;
        outcome <= OUT_NO_FRAME;
      end
    end
    if ((state == ST_FILL) && scan_done) begin
      tlb_page[victim]  <= page;
      tlb_frame[victim] <= frame;
      tlb_birth[victim] <= stamp;
    end
    if (out_load) begin
      pa_out  <= pa_next;
      m_tuser <= outcome;
    end
  end

  assign m_tdata = OUT_DATA_W'(pa_out);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("input taken again right after an accept");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= FREE_W'(FRAME_COUNT))
    else $error("frame allocation count past the frame pool");

  a_refill_valid: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FILL) && scan_done) |=> tlb_valid[$past(victim)])
    else $error("refilled TLB entry not valid");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == OUT_NO_FRAME)) |-> (m_tdata == '0))
    else $error("no-frame result carries a nonzero address");

endmodule

`default_nettype wire
